[sv/cas_pkg.sv]
// Shared constants and control types for the complex add/sub/mul/div core.
package cas_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	// Per-beat control that rides alongside the divider lanes.
	typedef struct packed {
		logic valid;
		logic neg_re;
		logic neg_im;
		logic big_re;
		logic big_im;
		logic dz;
	} cas_ctl_t;

endpackage

[sv/cas_front.sv]
// Front pipeline: operand capture, sum/difference, products, rescale and divider setup.
module cas_front #(
	parameter int DW = 16,
	parameter int FB = 8,
	parameter int RW = 3 * 16 + 8,
	parameter int SW = 6 * 16 + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [DW-1:0]   a_real,
	input  logic signed [DW-1:0]   a_imag,
	input  logic signed [DW-1:0]   b_real,
	input  logic signed [DW-1:0]   b_imag,
	output cas_pkg::cas_ctl_t      ctl_o,
	output logic [2*DW-1:0]        den_o,
	output logic [RW-1:0]          r_re_o,
	output logic [RW-1:0]          r_im_o,
	output logic [SW-1:0]          side_o
);
	import cas_pkg::*;

	localparam int PW = 2 * DW + 1;

	// saturating (DW+1)-bit result -> {ovf, value}
	function automatic logic [DW:0] sat_add(input logic [DW:0] s);
		logic [DW:0] r;
		if (s[DW] != s[DW-1]) begin
			r = {1'b1, s[DW], {(DW-1){~s[DW]}}};
		end else begin
			r = {1'b0, s[DW-1:0]};
		end
		return r;
	endfunction

	// stage 1: operands, sum and difference
	logic                 vld_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic [DW-1:0]        sr_s1, si_s1, dr_s1, di_s1;
	logic                 ovf_s1;
	logic [DW:0]          sr_c, si_c, dr_c, di_c;

	always_comb begin
		sr_c = sat_add({a_real[DW-1], a_real} + {b_real[DW-1], b_real});
		si_c = sat_add({a_imag[DW-1], a_imag} + {b_imag[DW-1], b_imag});
		dr_c = sat_add({a_real[DW-1], a_real} - {b_real[DW-1], b_real});
		di_c = sat_add({a_imag[DW-1], a_imag} - {b_imag[DW-1], b_imag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ar_s1  <= a_real;
			ai_s1  <= a_imag;
			br_s1  <= b_real;
			bi_s1  <= b_imag;
			sr_s1  <= sr_c[DW-1:0];
			si_s1  <= si_c[DW-1:0];
			dr_s1  <= dr_c[DW-1:0];
			di_s1  <= di_c[DW-1:0];
			ovf_s1 <= sr_c[DW] | si_c[DW] | dr_c[DW] | di_c[DW];
		end
	end

	// stage 2: partial products
	logic                   vld_s2, dz_s2, ovf_s2;
	logic signed [2*DW-1:0] arbr_s2, aibi_s2, aibr_s2, arbi_s2, brbr_s2, bibi_s2;
	logic [4*DW-1:0]        sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arbr_s2 <= ar_s1 * br_s1;
			aibi_s2 <= ai_s1 * bi_s1;
			aibr_s2 <= ai_s1 * br_s1;
			arbi_s2 <= ar_s1 * bi_s1;
			brbr_s2 <= br_s1 * br_s1;
			bibi_s2 <= bi_s1 * bi_s1;
			dz_s2   <= (br_s1 == '0) && (bi_s1 == '0);
			ovf_s2  <= ovf_s1;
			sd_s2   <= {di_s1, dr_s1, si_s1, sr_s1};
		end
	end

	// stage 3: cross sums and divisor
	logic                 vld_s3, dz_s3, ovf_s3;
	logic signed [PW-1:0] pr_s3, pi_s3, nr_s3, ni_s3;
	logic [2*DW-1:0]      den_s3;
	logic [4*DW-1:0]      sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s3  <= PW'(arbr_s2) - PW'(aibi_s2);
			pi_s3  <= PW'(aibr_s2) + PW'(arbi_s2);
			nr_s3  <= PW'(arbr_s2) + PW'(aibi_s2);
			ni_s3  <= PW'(aibr_s2) - PW'(arbi_s2);
			den_s3 <= unsigned'(brbr_s2) + unsigned'(bibi_s2);
			dz_s3  <= dz_s2;
			ovf_s3 <= ovf_s2;
			sd_s3  <= sd_s2;
		end
	end

	// stage 4: product rescale (floor) and saturate, numerator magnitudes
	localparam logic signed [PW-1:0] PMAX = PW'((2 ** (DW - 1)) - 1);
	localparam logic signed [PW-1:0] PMIN = -PW'(2 ** (DW - 1));

	logic signed [PW-1:0] pr_sh, pi_sh;
	logic [DW-1:0]        pr_c, pi_c;
	logic                 povf_c;
	logic [PW-1:0]        nr_abs, ni_abs;

	always_comb begin
		pr_sh  = pr_s3 >>> FB;
		pi_sh  = pi_s3 >>> FB;
		povf_c = 1'b0;
		if (pr_sh > PMAX) begin
			pr_c = PMAX[DW-1:0]; povf_c = 1'b1;
		end else if (pr_sh < PMIN) begin
			pr_c = PMIN[DW-1:0]; povf_c = 1'b1;
		end else begin
			pr_c = pr_sh[DW-1:0];
		end
		if (pi_sh > PMAX) begin
			pi_c = PMAX[DW-1:0]; povf_c = 1'b1;
		end else if (pi_sh < PMIN) begin
			pi_c = PMIN[DW-1:0]; povf_c = 1'b1;
		end else begin
			pi_c = pi_sh[DW-1:0];
		end
		nr_abs = nr_s3[PW-1] ? -nr_s3 : nr_s3;
		ni_abs = ni_s3[PW-1] ? -ni_s3 : ni_s3;
	end

	logic            vld_s4, dz_s4, ovf_s4, negr_s4, negi_s4;
	logic [2*DW-1:0] magr_s4, magi_s4, den_s4;
	logic [6*DW-1:0] sd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magr_s4 <= nr_abs[2*DW-1:0];
			magi_s4 <= ni_abs[2*DW-1:0];
			negr_s4 <= nr_s3[PW-1];
			negi_s4 <= ni_s3[PW-1];
			den_s4  <= den_s3;
			dz_s4   <= dz_s3;
			ovf_s4  <= ovf_s3 | povf_c;
			sd_s4   <= {pi_c, pr_c, sd_s3};
		end
	end

	// stage 5: scaled dividend and quotient range check
	logic [RW-1:0] dr_w, di_w, dbig_w;

	always_comb begin
		dr_w   = RW'(magr_s4) << FB;
		di_w   = RW'(magi_s4) << FB;
		dbig_w = RW'(den_s4) << DW;
	end

	logic            vld_s5, negr_s5, negi_s5, bigr_s5, bigi_s5, dz_s5;
	logic [2*DW-1:0] den_s5;
	logic [RW-1:0]   rr_s5, ri_s5;
	logic [SW-1:0]   side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negr_s5 <= negr_s4;
			negi_s5 <= negi_s4;
			bigr_s5 <= dr_w >= dbig_w;
			bigi_s5 <= di_w >= dbig_w;
			dz_s5   <= dz_s4;
			den_s5  <= den_s4;
			rr_s5   <= dr_w;
			ri_s5   <= di_w;
			side_s5 <= {ovf_s4, sd_s4};
		end
	end

	always_comb begin
		ctl_o.valid  = vld_s5;
		ctl_o.neg_re = negr_s5;
		ctl_o.neg_im = negi_s5;
		ctl_o.big_re = bigr_s5;
		ctl_o.big_im = bigi_s5;
		ctl_o.dz     = dz_s5;
	end

	assign den_o  = den_s5;
	assign r_re_o = rr_s5;
	assign r_im_o = ri_s5;
	assign side_o = side_s5;

endmodule

[sv/cas_div_step.sv]
// One restoring-division step for both quotient lanes, one quotient bit per stage.
module cas_div_step #(
	parameter int DW  = 16,
	parameter int RW  = 3 * 16 + 8,
	parameter int SW  = 6 * 16 + 1,
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cas_pkg::cas_ctl_t ctl_i,
	input  logic [2*DW-1:0]   den_i,
	input  logic [RW-1:0]     r_re_i,
	input  logic [RW-1:0]     r_im_i,
	input  logic [DW-1:0]     q_re_i,
	input  logic [DW-1:0]     q_im_i,
	input  logic [SW-1:0]     side_i,
	output cas_pkg::cas_ctl_t ctl_o,
	output logic [2*DW-1:0]   den_o,
	output logic [RW-1:0]     r_re_o,
	output logic [RW-1:0]     r_im_o,
	output logic [DW-1:0]     q_re_o,
	output logic [DW-1:0]     q_im_o,
	output logic [SW-1:0]     side_o
);
	import cas_pkg::*;

	logic [RW-1:0] dsh;
	logic          take_re, take_im;

	always_comb begin
		dsh     = RW'(den_i) << BIT;
		take_re = r_re_i >= dsh;
		take_im = r_im_i >= dsh;
	end

	logic            vld_s1, negr_s1, negi_s1, bigr_s1, bigi_s1, dz_s1;
	logic [2*DW-1:0] den_s1;
	logic [RW-1:0]   rr_s1, ri_s1;
	logic [DW-1:0]   qr_s1, qi_s1;
	logic [SW-1:0]   side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negr_s1 <= ctl_i.neg_re;
			negi_s1 <= ctl_i.neg_im;
			bigr_s1 <= ctl_i.big_re;
			bigi_s1 <= ctl_i.big_im;
			dz_s1   <= ctl_i.dz;
			den_s1  <= den_i;
			rr_s1   <= take_re ? r_re_i - dsh : r_re_i;
			ri_s1   <= take_im ? r_im_i - dsh : r_im_i;
			qr_s1   <= q_re_i | (DW'(take_re) << BIT);
			qi_s1   <= q_im_i | (DW'(take_im) << BIT);
			side_s1 <= side_i;
		end
	end

	always_comb begin
		ctl_o.valid  = vld_s1;
		ctl_o.neg_re = negr_s1;
		ctl_o.neg_im = negi_s1;
		ctl_o.big_re = bigr_s1;
		ctl_o.big_im = bigi_s1;
		ctl_o.dz     = dz_s1;
	end

	assign den_o  = den_s1;
	assign r_re_o = rr_s1;
	assign r_im_o = ri_s1;
	assign q_re_o = qr_s1;
	assign q_im_o = qi_s1;
	assign side_o = side_s1;

endmodule

[sv/complex_add_sub_mul_div_core.sv]
// Top level: complex add, subtract, multiply and divide stream core.
// Throughput: one beat per cycle; five front stages, one quotient bit per divider stage.
// Whole pipeline advances together; a stalled output beat (m_tvalid high, m_tready low)
// freezes every stage.
// arst_n clears all valid bits asynchronously; data registers are not reset.
module complex_add_sub_mul_div_core #(
	parameter int DATA_WIDTH = cas_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cas_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// a_real, a_imag, b_real, b_imag (lowest first), zero-padded to bytes
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// sum_real, sum_imag, diff_real, diff_imag, prod_real, prod_imag,
	// quot_real, quot_imag (lowest first)
	output logic [8*DATA_WIDTH-1:0]              m_tdata,
	// overflow, divide_by_zero (lowest first)
	output logic [1:0]                           m_tuser
);
	import cas_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int RW = 3 * DW + FRAC_BITS;
	localparam int SW = 6 * DW + 1;

	// global advance: output register free or being drained
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// divider chain wiring, index 0 is the front output
	cas_ctl_t        ctl_w  [DW+1];
	logic [2*DW-1:0] den_w  [DW+1];
	logic [RW-1:0]   rr_w   [DW+1];
	logic [RW-1:0]   ri_w   [DW+1];
	logic [DW-1:0]   qr_w   [DW+1];
	logic [DW-1:0]   qi_w   [DW+1];
	logic [SW-1:0]   side_w [DW+1];

	cas_front #(.DW(DW), .FB(FRAC_BITS), .RW(RW), .SW(SW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.a_real   (s_tdata[DW-1:0]),
		.a_imag   (s_tdata[2*DW-1:DW]),
		.b_real   (s_tdata[3*DW-1:2*DW]),
		.b_imag   (s_tdata[4*DW-1:3*DW]),
		.ctl_o    (ctl_w[0]),
		.den_o    (den_w[0]),
		.r_re_o   (rr_w[0]),
		.r_im_o   (ri_w[0]),
		.side_o   (side_w[0])
	);

	assign qr_w[0] = '0;
	assign qi_w[0] = '0;

	// quotient bits MSB first, one stage each
	for (genvar k = 0; k < DW; k++) begin : g_div
		cas_div_step #(.DW(DW), .RW(RW), .SW(SW), .BIT(DW - 1 - k)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_w[k]),
			.den_i  (den_w[k]),
			.r_re_i (rr_w[k]),
			.r_im_i (ri_w[k]),
			.q_re_i (qr_w[k]),
			.q_im_i (qi_w[k]),
			.side_i (side_w[k]),
			.ctl_o  (ctl_w[k+1]),
			.den_o  (den_w[k+1]),
			.r_re_o (rr_w[k+1]),
			.r_im_o (ri_w[k+1]),
			.q_re_o (qr_w[k+1]),
			.q_im_o (qi_w[k+1]),
			.side_o (side_w[k+1])
		);
	end

	// final quotient saturation; zero divisor forces zero with no overflow
	cas_ctl_t      cf;
	logic [DW-1:0] qr, qi, quot_re, quot_im;
	logic          qovf_re, qovf_im;

	always_comb begin
		cf = ctl_w[DW];
		qr = qr_w[DW];
		qi = qi_w[DW];
		if (cf.neg_re) begin
			qovf_re = cf.big_re || (qr[DW-1] && (qr[DW-2:0] != '0));
			quot_re = qovf_re ? {1'b1, {(DW-1){1'b0}}} : -qr;
		end else begin
			qovf_re = cf.big_re || qr[DW-1];
			quot_re = qovf_re ? {1'b0, {(DW-1){1'b1}}} : qr;
		end
		if (cf.neg_im) begin
			qovf_im = cf.big_im || (qi[DW-1] && (qi[DW-2:0] != '0));
			quot_im = qovf_im ? {1'b1, {(DW-1){1'b0}}} : -qi;
		end else begin
			qovf_im = cf.big_im || qi[DW-1];
			quot_im = qovf_im ? {1'b0, {(DW-1){1'b1}}} : qi;
		end
		if (cf.dz) begin
			quot_re = '0;
			quot_im = '0;
			qovf_re = 1'b0;
			qovf_im = 1'b0;
		end
	end

	// output register
	logic                 vld_q;
	logic [8*DW-1:0]      data_q;
	logic [1:0]           user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= cf.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {quot_im, quot_re, side_w[DW][6*DW-1:0]};
			user_q <= {cf.dz, side_w[DW][6*DW] | qovf_re | qovf_im};
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

[sv/cas_checker.sv]
// Port-level checker for the complex core, bound to the top level.
module cas_checker #(
	parameter int DW = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [8*DW-1:0]                   m_tdata,
	input logic [1:0]                        m_tuser
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// input side is backpressured only by a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not track output stall");

	// zero divisor gives zero quotient parts
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[8*DW-1:6*DW] == '0)
		else $error("quotient not zero on divide by zero");

	// nothing comes out in the cycle after reset is released
	a_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind complex_add_sub_mul_div_core cas_checker #(.DW(DATA_WIDTH)) u_cas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
